@@ rtl/kce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_pkg
// shared types, codes and constants of the k-means clustering engine
// ----------------------------------------------------------------------------
package kce_pkg;

    localparam int COORD_W       = 32;
    localparam int NCL_W         = 4;
    localparam int NDIM_W        = 4;
    localparam int ITER_W        = 10;
    localparam int EPS_W         = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int OUT_IDX_W     = 3;
    localparam int STATUS_W      = 2;

    localparam int DEF_MAX_CLUSTERS = 8;
    localparam int DEF_MAX_DIMS     = 8;
    localparam int DEF_MAX_POINTS   = 1024;

    localparam logic [NCL_W-1:0]  RST_NUM_CLUSTERS = NCL_W'(2);
    localparam logic [NDIM_W-1:0] RST_NUM_DIMS     = NDIM_W'(2);
    localparam logic [ITER_W-1:0] RST_MAX_ITER     = ITER_W'(200);
    localparam logic [EPS_W-1:0]  RST_EPSILON_SQ   = EPS_W'(4295);

    localparam int MIN_CLUSTERS = 2;
    localparam int MIN_DIMS     = 1;
    localparam int MIN_ITER     = 2;
    localparam int MAX_ITER     = 999;

    // cycles from the last operand into the squared-distance unit to a settled sum
    localparam int DRAIN_CYC    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_CLUSTERS = 2'd0,
        CFG_NUM_DIMS     = 2'd1,
        CFG_MAX_ITER     = 2'd2,
        CFG_EPSILON_SQ   = 2'd3
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FEW     = 2'd1,
        ST_DROPPED = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_LOAD, S_FILL, S_START, S_SEED_RD, S_SEED_WR, S_IT_INIT, S_CLR,
        S_A_ISS, S_A_WAIT, S_A_CMP, S_S_RD, S_S_WR,
        S_U_RD, S_U_DIV, S_U_DWT, S_U_WR, S_U_SH, S_U_CHK,
        S_O_RD, S_O_LD, S_O_VAL, S_ERR
    } t_state;

endpackage

@@ rtl/kce_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_in_if
// coordinate stream channel, valid/ready
// ----------------------------------------------------------------------------
interface kce_in_if import kce_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coordinate;
    logic                      last_of_set;

    modport source (output valid, output coordinate, output last_of_set, input ready);
    modport sink   (input valid, input coordinate, input last_of_set, output ready);
endinterface

@@ rtl/kce_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_out_if
// centroid result channel, valid/ready
// ----------------------------------------------------------------------------
interface kce_out_if import kce_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [OUT_IDX_W-1:0]        centroid_index;
    logic [OUT_IDX_W-1:0]        dim_index;
    logic signed [COORD_W-1:0]   centroid_value;
    logic [STATUS_W-1:0]         status;
    logic                        last;

    modport source (output valid, output centroid_index, output dim_index,
                    output centroid_value, output status, output last, input ready);
    modport sink   (input valid, input centroid_index, input dim_index,
                    input centroid_value, input status, input last, output ready);
endinterface

@@ rtl/kce_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module kce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/kce_dsq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_dsq
// shared squared-distance unit: |a-b|, square, accumulate (three stages)
// ----------------------------------------------------------------------------
module kce_dsq import kce_pkg::*; #(
    parameter int ACC_W = 2 * COORD_W + 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clr,
    input  logic                      i_valid,
    input  logic signed [COORD_W-1:0] i_a,
    input  logic signed [COORD_W-1:0] i_b,
    output logic [ACC_W-1:0]          o_acc
);
    logic signed [COORD_W:0] diff;
    logic [COORD_W-1:0]      mag;
    logic                    r_v1, r_v2;
    logic [COORD_W-1:0]      r_mag;
    logic [2*COORD_W-1:0]    r_sq;
    logic [ACC_W-1:0]        r_acc;

    always_comb begin
        diff = {i_a[COORD_W-1], i_a} - {i_b[COORD_W-1], i_b};
        mag  = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            if (i_clr) begin
                r_acc <= '0;
            end else if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_sq);
            end
        end
        r_mag <= mag;
        r_sq  <= r_mag * r_mag;
    end

    assign o_acc = r_acc;
endmodule

@@ rtl/kce_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_div
// radix-2 restoring divider, signed sum by point count, truncates toward zero
// ----------------------------------------------------------------------------
module kce_div import kce_pkg::*; #(
    parameter int SUM_W = 42,
    parameter int CNT_W = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]        i_divisor,
    output logic                    o_busy,
    output logic [COORD_W-1:0]      o_quot
);
    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic              r_neg;
    logic [SUM_W-1:0]  r_num;
    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [CNT_W:0]    trial;
    logic              fits;
    logic [SUM_W-1:0]  q_signed;

    always_comb begin
        trial    = {r_rem, r_num[SUM_W-1]};
        fits     = trial >= {1'b0, r_den};
        q_signed = r_neg ? -r_q : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_step == STEP_W'(SUM_W - 1)) begin
            r_busy <= 1'b0;
        end
        if (i_start) begin
            r_step <= '0;
            r_neg  <= i_dividend[SUM_W-1];
            r_num  <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            r_q    <= '0;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            r_num  <= r_num << 1;
            r_q    <= {r_q[SUM_W-2:0], fits};
            r_rem  <= fits ? CNT_W'(trial - {1'b0, r_den}) : CNT_W'(trial);
        end
    end

    assign o_busy = r_busy;
    assign o_quot = q_signed[COORD_W-1:0];
endmodule

@@ rtl/kmeans_clustering_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_clustering_engine
// lloyd k-means over signed q16.16 points with a shared distance unit
// ----------------------------------------------------------------------------
// Points are loaded one coordinate per transfer, one per cycle, num_dims
// coordinates per point. The transfer carrying last_of_set closes the set and
// starts the run; input is stalled until the last result has been taken. The
// first K points seed the centroids, then each iteration assigns every point
// to its nearest centroid (exact squared distance, ties to the lower index),
// sums the points per cluster and divides by the count (truncating). The run
// stops at the iteration limit or when every centroid moved less than
// epsilon_sq (squared, q32.32), then K*num_dims results come out centroid by
// centroid. Run time is set by the per-point distance loop through the single
// squared-distance unit and by the one-bit-per-cycle divider over sums of
// SUM_W = 32 + log2(MAX_POINTS) bits. Too few points (no more than K) gives
// one result with status 1; points past MAX_POINTS are dropped and every
// result carries status 2.
module kmeans_clustering_engine import kce_pkg::*; #(
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int MAX_DIMS     = DEF_MAX_DIMS,
    parameter int MAX_POINTS   = DEF_MAX_POINTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    kce_in_if.sink                i_pt,
    kce_out_if.source             o_res
);
    localparam int KW  = $clog2(MAX_CLUSTERS);
    localparam int KUW = $clog2(MAX_CLUSTERS + 1);
    localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DUW = $clog2(MAX_DIMS + 1);
    localparam int PIW = $clog2(MAX_POINTS);
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int PAW = $clog2(MAX_POINTS * MAX_DIMS);
    localparam int CAW = $clog2(MAX_CLUSTERS * MAX_DIMS);
    localparam int SW  = COORD_W + $clog2(MAX_POINTS);
    localparam int AW  = 2 * COORD_W + $clog2(MAX_DIMS);
    localparam int WW  = $clog2(DRAIN_CYC);

    // configuration
    logic [NCL_W-1:0]  r_ncl;
    logic [NDIM_W-1:0] r_ndim;
    logic [ITER_W-1:0] r_maxit;
    logic [EPS_W-1:0]  r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncl   <= RST_NUM_CLUSTERS;
            r_ndim  <= RST_NUM_DIMS;
            r_maxit <= RST_MAX_ITER;
            r_eps   <= RST_EPSILON_SQ;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_CLUSTERS: r_ncl   <= i_cfg_data[NCL_W-1:0];
                CFG_NUM_DIMS:     r_ndim  <= i_cfg_data[NDIM_W-1:0];
                CFG_MAX_ITER:     r_maxit <= i_cfg_data[ITER_W-1:0];
                CFG_EPSILON_SQ:   r_eps   <= i_cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // registers saturated to their legal ranges
    logic [KUW-1:0]    k_u;
    logic [DUW-1:0]    d_u;
    logic [ITER_W-1:0] it_u;

    always_comb begin
        if (int'(r_ncl) < MIN_CLUSTERS)      k_u = KUW'(MIN_CLUSTERS);
        else if (int'(r_ncl) > MAX_CLUSTERS) k_u = KUW'(MAX_CLUSTERS);
        else                                 k_u = KUW'(r_ncl);
        if (int'(r_ndim) < MIN_DIMS)         d_u = DUW'(MIN_DIMS);
        else if (int'(r_ndim) > MAX_DIMS)    d_u = DUW'(MAX_DIMS);
        else                                 d_u = DUW'(r_ndim);
        if (int'(r_maxit) < MIN_ITER)        it_u = ITER_W'(MIN_ITER);
        else if (int'(r_maxit) > MAX_ITER)   it_u = ITER_W'(MAX_ITER);
        else                                 it_u = r_maxit;
    end

    // sequencer state
    t_state            r_state, n_state;
    logic [PCW-1:0]    r_pl, n_pl;          // points loaded
    logic [DW-1:0]     r_dp, n_dp;          // coordinate position in point
    logic              r_ovf, n_ovf;
    logic [PIW-1:0]    r_fp, n_fp;          // point being zero-filled
    logic [KW-1:0]     r_i, n_i;
    logic [DW-1:0]     r_j, n_j;
    logic [PIW-1:0]    r_p, n_p;
    logic [ITER_W-1:0] r_it, n_it;
    logic [AW-1:0]     r_best, n_best;
    logic [KW-1:0]     r_bi, n_bi;
    logic              r_conv, n_conv;
    logic [WW-1:0]     r_wait, n_wait;
    logic              r_feed, n_feed;
    logic              r_zero, n_zero;
    logic [COORD_W-1:0] r_old, n_old;
    logic [COORD_W-1:0] r_ov, n_ov;
    logic [PCW-1:0]    r_cnt [MAX_CLUSTERS];
    logic [PCW-1:0]    n_cnt [MAX_CLUSTERS];

    // memories and units
    logic               pt_we;
    logic [PAW-1:0]     pt_waddr, pt_raddr;
    logic [COORD_W-1:0] pt_wdata, pt_rdata;
    logic               cen_we;
    logic [CAW-1:0]     cen_waddr, cen_raddr;
    logic [COORD_W-1:0] cen_wdata, cen_rdata;
    logic               sum_we;
    logic [CAW-1:0]     sum_waddr, sum_raddr;
    logic [SW-1:0]      sum_wdata, sum_rdata;
    logic               dsq_clr, dsq_valid;
    logic [COORD_W-1:0] dsq_a, dsq_b;
    logic [AW-1:0]      dsq_acc;
    logic               div_start, div_busy;
    logic [COORD_W-1:0] div_q;

    function automatic logic [PAW-1:0] pt_addr(input logic [PIW-1:0] p,
                                               input logic [DW-1:0] j);
        return PAW'(p) * PAW'(MAX_DIMS) + PAW'(j);
    endfunction

    function automatic logic [CAW-1:0] cl_addr(input logic [KW-1:0] i,
                                               input logic [DW-1:0] j);
        return CAW'(i) * CAW'(MAX_DIMS) + CAW'(j);
    endfunction

    kce_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS * MAX_DIMS)) u_pt_ram (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(pt_waddr), .i_wdata(pt_wdata),
        .i_raddr(pt_raddr), .o_rdata(pt_rdata)
    );

    kce_ram #(.WIDTH(COORD_W), .DEPTH(MAX_CLUSTERS * MAX_DIMS)) u_cen_ram (
        .i_clk(i_clk), .i_we(cen_we), .i_waddr(cen_waddr), .i_wdata(cen_wdata),
        .i_raddr(cen_raddr), .o_rdata(cen_rdata)
    );

    kce_ram #(.WIDTH(SW), .DEPTH(MAX_CLUSTERS * MAX_DIMS)) u_sum_ram (
        .i_clk(i_clk), .i_we(sum_we), .i_waddr(sum_waddr), .i_wdata(sum_wdata),
        .i_raddr(sum_raddr), .o_rdata(sum_rdata)
    );

    kce_dsq #(.ACC_W(AW)) u_dsq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clr(dsq_clr), .i_valid(dsq_valid),
        .i_a(dsq_a), .i_b(dsq_b), .o_acc(dsq_acc)
    );

    kce_div #(.SUM_W(SW), .CNT_W(PCW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(sum_rdata), .i_divisor(r_cnt[r_i]),
        .o_busy(div_busy), .o_quot(div_q)
    );

    // loop end tests
    logic i_last, j_last, p_last, room, pt_done, wait_done;
    logic [COORD_W-1:0] new_val;

    always_comb begin
        i_last    = (KUW'(r_i) + KUW'(1)) == k_u;
        j_last    = (DUW'(r_j) + DUW'(1)) == d_u;
        p_last    = (PCW'(r_p) + PCW'(1)) == r_pl;
        room      = r_pl < PCW'(MAX_POINTS);
        pt_done   = i_pt.last_of_set || ((DUW'(r_dp) + DUW'(1)) >= d_u);
        wait_done = r_wait == WW'(DRAIN_CYC - 1);
        new_val   = r_zero ? '0 : div_q;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pl    = r_pl;
        n_dp    = r_dp;
        n_ovf   = r_ovf;
        n_fp    = r_fp;
        n_i     = r_i;
        n_j     = r_j;
        n_p     = r_p;
        n_it    = r_it;
        n_best  = r_best;
        n_bi    = r_bi;
        n_conv  = r_conv;
        n_wait  = r_wait + WW'(1);
        n_feed  = 1'b0;
        n_zero  = r_zero;
        n_old   = r_old;
        n_ov    = r_ov;
        n_cnt   = r_cnt;

        case (r_state)
            S_LOAD: begin
                if (i_pt.valid) begin
                    if (!room) n_ovf = 1'b1;
                    if (pt_done) begin
                        if (room) n_pl = r_pl + PCW'(1);
                        n_dp = '0;
                    end else begin
                        n_dp = r_dp + DW'(1);
                    end
                    if (i_pt.last_of_set) begin
                        // short final point: zero the missing coordinates
                        if (room && (DUW'(r_dp) + DUW'(1)) < d_u) begin
                            n_fp    = r_pl[PIW-1:0];
                            n_j     = r_dp + DW'(1);
                            n_state = S_FILL;
                        end else begin
                            n_state = S_START;
                        end
                    end
                end
            end
            S_FILL: begin
                n_j = r_j + DW'(1);
                if (j_last) n_state = S_START;
            end
            S_START: begin
                n_i = '0;
                n_j = '0;
                n_it = '0;
                if (int'(r_pl) <= int'(k_u)) n_state = S_ERR;
                else                         n_state = S_SEED_RD;
            end
            S_SEED_RD: n_state = S_SEED_WR;
            S_SEED_WR: begin
                n_state = S_SEED_RD;
                if (j_last) begin
                    n_j = '0;
                    n_i = r_i + KW'(1);
                    if (i_last) begin
                        n_i = '0;
                        n_state = S_IT_INIT;
                    end
                end else begin
                    n_j = r_j + DW'(1);
                end
            end
            S_IT_INIT: begin
                for (int c = 0; c < MAX_CLUSTERS; c++) n_cnt[c] = '0;
                n_conv  = 1'b1;
                n_i     = '0;
                n_j     = '0;
                n_state = S_CLR;
            end
            S_CLR: begin
                if (j_last) begin
                    n_j = '0;
                    n_i = r_i + KW'(1);
                    if (i_last) begin
                        n_i = '0;
                        n_p = '0;
                        n_state = S_A_ISS;
                    end
                end else begin
                    n_j = r_j + DW'(1);
                end
            end
            S_A_ISS: begin
                n_feed = 1'b1;
                if (j_last) begin
                    n_j = '0;
                    n_wait = '0;
                    n_state = S_A_WAIT;
                end else begin
                    n_j = r_j + DW'(1);
                end
            end
            S_A_WAIT: if (wait_done) n_state = S_A_CMP;
            S_A_CMP: begin
                if (r_i == '0 || dsq_acc < r_best) begin
                    n_best = dsq_acc;
                    n_bi   = r_i;
                end
                if (i_last) begin
                    n_j = '0;
                    n_state = S_S_RD;
                end else begin
                    n_i = r_i + KW'(1);
                    n_state = S_A_ISS;
                end
            end
            S_S_RD: n_state = S_S_WR;
            S_S_WR: begin
                if (j_last) begin
                    n_cnt[r_bi] = r_cnt[r_bi] + PCW'(1);
                    n_j = '0;
                    n_i = '0;
                    if (p_last) begin
                        n_state = S_U_RD;
                    end else begin
                        n_p = r_p + PIW'(1);
                        n_state = S_A_ISS;
                    end
                end else begin
                    n_j = r_j + DW'(1);
                    n_state = S_S_RD;
                end
            end
            S_U_RD: n_state = S_U_DIV;
            S_U_DIV: begin
                n_old  = cen_rdata;
                n_zero = r_cnt[r_i] == '0;
                n_state = S_U_DWT;
            end
            S_U_DWT: if (r_zero || !div_busy) n_state = S_U_WR;
            S_U_WR: begin
                if (j_last) begin
                    n_j = '0;
                    n_wait = '0;
                    n_state = S_U_SH;
                end else begin
                    n_j = r_j + DW'(1);
                    n_state = S_U_RD;
                end
            end
            S_U_SH: if (wait_done) n_state = S_U_CHK;
            S_U_CHK: begin
                n_conv = r_conv && (dsq_acc < AW'(r_eps));
                if (i_last) begin
                    n_i = '0;
                    n_j = '0;
                    if (n_conv || (r_it + ITER_W'(1)) == it_u) begin
                        n_state = S_O_RD;
                    end else begin
                        n_it = r_it + ITER_W'(1);
                        n_state = S_IT_INIT;
                    end
                end else begin
                    n_i = r_i + KW'(1);
                    n_state = S_U_RD;
                end
            end
            S_O_RD: n_state = S_O_LD;
            S_O_LD: begin
                n_ov = cen_rdata;
                n_state = S_O_VAL;
            end
            S_O_VAL: begin
                if (o_res.ready) begin
                    if (i_last && j_last) begin
                        n_pl = '0;
                        n_dp = '0;
                        n_ovf = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_O_RD;
                        if (j_last) begin
                            n_j = '0;
                            n_i = r_i + KW'(1);
                        end else begin
                            n_j = r_j + DW'(1);
                        end
                    end
                end
            end
            S_ERR: begin
                if (o_res.ready) begin
                    n_pl = '0;
                    n_dp = '0;
                    n_ovf = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // memory, unit and port controls
    always_comb begin
        pt_we     = 1'b0;
        pt_waddr  = pt_addr(r_pl[PIW-1:0], r_dp);
        pt_wdata  = i_pt.coordinate;
        pt_raddr  = pt_addr(r_p, r_j);
        cen_we    = 1'b0;
        cen_waddr = cl_addr(r_i, r_j);
        cen_wdata = new_val;
        cen_raddr = cl_addr(r_i, r_j);
        sum_we    = 1'b0;
        sum_waddr = cl_addr(r_i, r_j);
        sum_wdata = '0;
        sum_raddr = cl_addr(r_i, r_j);
        dsq_clr   = 1'b0;
        dsq_valid = r_feed;
        dsq_a     = pt_rdata;
        dsq_b     = cen_rdata;
        div_start = 1'b0;

        i_pt.ready           = r_state == S_LOAD;
        o_res.valid          = 1'b0;
        o_res.centroid_index = OUT_IDX_W'(r_i);
        o_res.dim_index      = OUT_IDX_W'(r_j);
        o_res.centroid_value = r_ov;
        o_res.status         = r_ovf ? ST_DROPPED : ST_OK;
        o_res.last           = i_last && j_last;

        case (r_state)
            S_LOAD: pt_we = i_pt.valid && room;
            S_FILL: begin
                pt_we    = 1'b1;
                pt_waddr = pt_addr(r_fp, r_j);
                pt_wdata = '0;
            end
            S_SEED_RD: pt_raddr = pt_addr(PIW'(r_i), r_j);
            S_SEED_WR: begin
                cen_we    = 1'b1;
                cen_wdata = pt_rdata;
            end
            S_CLR: sum_we = 1'b1;
            S_A_ISS: dsq_clr = r_j == '0;
            S_S_RD: sum_raddr = cl_addr(r_bi, r_j);
            S_S_WR: begin
                sum_we    = 1'b1;
                sum_waddr = cl_addr(r_bi, r_j);
                sum_wdata = sum_rdata + SW'(signed'(pt_rdata));
            end
            S_U_RD: dsq_clr = r_j == '0;
            S_U_DIV: div_start = r_cnt[r_i] != '0;
            S_U_WR: begin
                cen_we    = 1'b1;
                dsq_valid = 1'b1;
                dsq_a     = r_old;
                dsq_b     = new_val;
            end
            S_O_VAL: o_res.valid = 1'b1;
            S_ERR: begin
                o_res.valid          = 1'b1;
                o_res.centroid_index = '0;
                o_res.dim_index      = '0;
                o_res.centroid_value = '0;
                o_res.status         = ST_FEW;
                o_res.last           = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_pl    <= '0;
            r_dp    <= '0;
            r_ovf   <= 1'b0;
            r_feed  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pl    <= n_pl;
            r_dp    <= n_dp;
            r_ovf   <= n_ovf;
            r_feed  <= n_feed;
        end
        r_fp   <= n_fp;
        r_i    <= n_i;
        r_j    <= n_j;
        r_p    <= n_p;
        r_it   <= n_it;
        r_best <= n_best;
        r_bi   <= n_bi;
        r_conv <= n_conv;
        r_wait <= n_wait;
        r_zero <= n_zero;
        r_old  <= n_old;
        r_ov   <= n_ov;
        r_cnt  <= n_cnt;
    end
endmodule
